// ===== src/chs_pkg.sv =====
`default_nettype none

package chs_pkg;

    // Item kinds on the input channel.
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_CHANNELS = 1'b0;
    localparam logic CFG_ANTENNAS = 1'b1;

    // Field and register widths fixed by the interface.
    localparam int KIND_W     = 2;
    localparam int SAMPLE_W   = 8;
    localparam int RD_CH_W    = 6;
    localparam int RD_ANT_W   = 4;
    localparam int BIN_W      = 8;
    localparam int BIN_COUNT  = 256;
    localparam int OUT_W      = 32;
    localparam int CFG_CH_W   = 7;
    localparam int CFG_ANT_W  = 5;
    localparam int CFG_DATA_W = 7;

    // Register values after reset.
    localparam logic [CFG_CH_W-1:0]  CFG_CH_RESET  = 7'd40;
    localparam logic [CFG_ANT_W-1:0] CFG_ANT_RESET = 5'd16;

    // One input item as held by the datapath.
    typedef struct packed {
        logic [KIND_W-1:0]          kind;
        logic signed [SAMPLE_W-1:0] real_sample;
        logic signed [SAMPLE_W-1:0] imag_sample;
        logic [RD_CH_W-1:0]         read_channel;
        logic [RD_ANT_W-1:0]        read_antenna;
        logic [BIN_W-1:0]           read_bin;
    } t_in_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic clear_start;
        logic clear_wr;
        logic sample_wr;
        logic load_out;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_ctrl_status;

endpackage

`default_nettype wire

// ===== src/chs_in_if.sv =====
`default_nettype none

interface chs_in_if;
    import chs_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [KIND_W-1:0]          kind;
    logic signed [SAMPLE_W-1:0] real_sample;
    logic signed [SAMPLE_W-1:0] imag_sample;
    logic [RD_CH_W-1:0]         read_channel;
    logic [RD_ANT_W-1:0]        read_antenna;
    logic [BIN_W-1:0]           read_bin;

    modport source (
        output valid, kind, real_sample, imag_sample, read_channel, read_antenna, read_bin,
        input  ready
    );

    modport sink (
        input  valid, kind, real_sample, imag_sample, read_channel, read_antenna, read_bin,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/chs_out_if.sv =====
`default_nettype none

interface chs_out_if;
    import chs_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] real_count;
    logic [OUT_W-1:0] imag_count;

    modport source (
        output valid, real_count, imag_count,
        input  ready
    );

    modport sink (
        input  valid, real_count, imag_count,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/chs_ctrl.sv =====
`default_nettype none

module chs_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire logic [1:0]                i_in_kind,
    input  wire chs_pkg::t_ctrl_status     i_status,
    output logic                           o_in_ready,
    output chs_pkg::t_ctrl_cmd             o_cmd
);
    import chs_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_READ   = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;
    localparam logic [1:0] S_CLEAR  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_is_read, n_is_read;

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        n_is_read  = r_is_read;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_is_read     = (i_in_kind == KIND_READ);
                    if (i_in_kind inside {KIND_SAMPLE, KIND_READ}) begin
                        n_state = S_READ;
                    end else if (i_in_kind == KIND_CLEAR) begin
                        o_cmd.clear_start = 1'b1;
                        n_state           = S_CLEAR;
                    end
                end
            end
            S_READ: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (!r_is_read) begin
                    o_cmd.sample_wr = 1'b1;
                    n_state         = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers; reset starts a sweep of the store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_is_read <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_is_read <= n_is_read;
        end
    end

`ifndef NO_ASSERTIONS
    a_clear_enters_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.capture && i_in_kind == KIND_CLEAR) |=> (r_state == S_CLEAR))
        else $error("clear item did not start the sweep");

    a_read_then_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_state == S_UPDATE))
        else $error("memory read not followed by update");

    a_sweep_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && !i_status.clear_last) |=> (r_state == S_CLEAR))
        else $error("sweep left before the last entry");
`endif

endmodule

`default_nettype wire

// ===== src/chs_datapath.sv =====
`default_nettype none

module chs_datapath #(
    parameter int MAX_CHANNELS = 64,
    parameter int MAX_ANTENNAS = 16,
    parameter int COUNT_WIDTH  = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic                            i_cfg_index,
    input  wire logic [chs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire chs_pkg::t_in_item               i_item,
    input  wire chs_pkg::t_ctrl_cmd              i_cmd,
    output chs_pkg::t_ctrl_status                o_status,
    input  wire logic                            i_out_ready,
    output logic                                 o_out_valid,
    output logic [chs_pkg::OUT_W-1:0]            o_real_count,
    output logic [chs_pkg::OUT_W-1:0]            o_imag_count
);
    import chs_pkg::*;

    localparam int ROWS   = MAX_CHANNELS * MAX_ANTENNAS;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CH_IW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int ANT_IW = (MAX_ANTENNAS > 1) ? $clog2(MAX_ANTENNAS) : 1;
    localparam int AW     = ROW_W + BIN_W;
    localparam int DEPTH  = ROWS * BIN_COUNT;
    localparam int NCH_W  = (($clog2(MAX_CHANNELS + 1) > CFG_CH_W) ?
                             $clog2(MAX_CHANNELS + 1) : CFG_CH_W) + 1;
    localparam int NANT_W = (($clog2(MAX_ANTENNAS + 1) > CFG_ANT_W) ?
                             $clog2(MAX_ANTENNAS + 1) : CFG_ANT_W) + 1;

    // Configuration registers.
    logic [CFG_CH_W-1:0]  r_cfg_ch;
    logic [CFG_ANT_W-1:0] r_cfg_ant;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ch  <= CFG_CH_RESET;
            r_cfg_ant <= CFG_ANT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_CHANNELS) begin
                r_cfg_ch <= i_cfg_data[CFG_CH_W-1:0];
            end else begin
                r_cfg_ant <= i_cfg_data[CFG_ANT_W-1:0];
            end
        end
    end

    // Effective counts: zero counts as one, large values clamp to the maximum.
    logic [NCH_W-1:0]  nch;
    logic [NANT_W-1:0] nant;

    always_comb begin
        if (r_cfg_ch == '0) begin
            nch = NCH_W'(1);
        end else if (NCH_W'(r_cfg_ch) > NCH_W'(MAX_CHANNELS)) begin
            nch = NCH_W'(MAX_CHANNELS);
        end else begin
            nch = NCH_W'(r_cfg_ch);
        end
        if (r_cfg_ant == '0) begin
            nant = NANT_W'(1);
        end else if (NANT_W'(r_cfg_ant) > NANT_W'(MAX_ANTENNAS)) begin
            nant = NANT_W'(MAX_ANTENNAS);
        end else begin
            nant = NANT_W'(r_cfg_ant);
        end
    end

    // Item register.
    t_in_item r_item;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
    end

    // Frame position counters and the sweep address.
    logic [CFG_CH_W-1:0]  r_ch_pos;
    logic [CFG_ANT_W-1:0] r_ant_pos;
    logic [AW-1:0]        r_clr_addr;
    logic                 ant_wrap;
    logic                 ch_wrap;

    assign ant_wrap = (NANT_W'(r_ant_pos) + NANT_W'(1)) >= nant;
    assign ch_wrap  = (NCH_W'(r_ch_pos) + NCH_W'(1)) >= nch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch_pos   <= '0;
            r_ant_pos  <= '0;
            r_clr_addr <= '0;
        end else if (i_cmd.clear_start) begin
            r_ch_pos   <= '0;
            r_ant_pos  <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.clear_wr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.sample_wr) begin
                if (ant_wrap) begin
                    r_ant_pos <= '0;
                    r_ch_pos  <= ch_wrap ? '0 : r_ch_pos + CFG_CH_W'(1);
                end else begin
                    r_ant_pos <= r_ant_pos + CFG_ANT_W'(1);
                end
            end
        end
    end

    // Store addresses: row from position or read fields, bin below it.
    logic              is_read;
    logic [CH_IW-1:0]  ch_idx;
    logic [ANT_IW-1:0] ant_idx;
    logic [ROW_W-1:0]  row;
    logic [BIN_W-1:0]  re_bin;
    logic [BIN_W-1:0]  im_bin;
    logic [AW-1:0]     re_addr;
    logic [AW-1:0]     im_addr;
    logic              in_range;

    assign is_read  = (r_item.kind == KIND_READ);
    assign ch_idx   = is_read ? CH_IW'(r_item.read_channel) : CH_IW'(r_ch_pos);
    assign ant_idx  = is_read ? ANT_IW'(r_item.read_antenna) : ANT_IW'(r_ant_pos);
    assign row      = ROW_W'(ch_idx * MAX_ANTENNAS) + ROW_W'(ant_idx);
    assign re_bin   = is_read ? r_item.read_bin
                              : {~r_item.real_sample[SAMPLE_W-1], r_item.real_sample[SAMPLE_W-2:0]};
    assign im_bin   = is_read ? r_item.read_bin
                              : {~r_item.imag_sample[SAMPLE_W-1], r_item.imag_sample[SAMPLE_W-2:0]};
    assign re_addr  = {row, re_bin};
    assign im_addr  = {row, im_bin};
    assign in_range = (32'(r_item.read_channel) < 32'(MAX_CHANNELS)) &&
                      (32'(r_item.read_antenna) < 32'(MAX_ANTENNAS));

    // Count memories, one for real parts and one for imaginary parts.
    logic [COUNT_WIDTH-1:0] mem_re [DEPTH];
    logic [COUNT_WIDTH-1:0] mem_im [DEPTH];
    logic [COUNT_WIDTH-1:0] r_rd_re;
    logic [COUNT_WIDTH-1:0] r_rd_im;
    logic                   mem_we;
    logic [AW-1:0]          wr_re_addr;
    logic [AW-1:0]          wr_im_addr;
    logic [COUNT_WIDTH-1:0] wr_re_data;
    logic [COUNT_WIDTH-1:0] wr_im_data;

    assign mem_we     = i_cmd.clear_wr || i_cmd.sample_wr;
    assign wr_re_addr = i_cmd.clear_wr ? r_clr_addr : re_addr;
    assign wr_im_addr = i_cmd.clear_wr ? r_clr_addr : im_addr;
    assign wr_re_data = i_cmd.clear_wr ? '0 :
                        (&r_rd_re) ? r_rd_re : r_rd_re + COUNT_WIDTH'(1);
    assign wr_im_data = i_cmd.clear_wr ? '0 :
                        (&r_rd_im) ? r_rd_im : r_rd_im + COUNT_WIDTH'(1);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_re[wr_re_addr] <= wr_re_data;
        end
        r_rd_re <= mem_re[re_addr];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_im[wr_im_addr] <= wr_im_data;
        end
        r_rd_im <= mem_im[im_addr];
    end

    // Output register for read results.
    logic             r_out_valid;
    logic [OUT_W-1:0] r_real_count;
    logic [OUT_W-1:0] r_imag_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_real_count <= in_range ? OUT_W'(r_rd_re) : '0;
            r_imag_count <= in_range ? OUT_W'(r_rd_im) : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_real_count = r_real_count;
    assign o_imag_count = r_imag_count;

    assign o_status.clear_last = (r_clr_addr == AW'(DEPTH - 1));
    assign o_status.out_free   = !r_out_valid || i_out_ready;

`ifndef NO_ASSERTIONS
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.sample_wr && i_cmd.clear_wr))
        else $error("sample update and sweep write in the same cycle");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !i_cmd.load_out)
        else $error("result overwritten while the receiver stalls");

    a_clear_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_start |=> (r_clr_addr == '0 && r_ch_pos == '0 && r_ant_pos == '0))
        else $error("clear did not reset positions and sweep address");
`endif

endmodule

`default_nettype wire

// ===== src/complex_sample_histogram.sv =====
`default_nettype none

// Histogram of signed 8-bit complex samples, per channel and antenna.
// Input channel i_in carries items of three kinds: a sample, a read of one
// bin, or a clear of the whole store. Samples are taken in frame order with
// the antenna running fastest; each one adds one, saturating, to the bin of
// its real part and to the bin of its imaginary part (value plus 128).
// A read item gives one result on o_out with both counts of the chosen bin.
// Sample and read items each pass through accept, a registered read of the
// two count memories, then the update write or the result load. The single
// read-modify-write through the memory ports sets these steps; a new item is
// accepted in the cycle after the previous one finishes.
// A clear item, and reset, run a sweep that writes zero to every entry, one
// entry per cycle, during which no item is accepted. Configuration writes on
// i_cfg_we / i_cfg_index / i_cfg_data are taken at any time.
// Results sit in an output register; while the receiver stalls, sample items
// carry on, but a further read item waits in its update step and holds off
// the input until the pending result has been taken.
// Reset restores the register defaults (40 channels, 16 antennas).
module complex_sample_histogram #(
    parameter int MAX_CHANNELS = 64,
    parameter int MAX_ANTENNAS = 16,
    parameter int COUNT_WIDTH  = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_index,
    input  wire logic [chs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    chs_in_if.sink                              i_in,
    chs_out_if.source                           o_out
);
    import chs_pkg::*;

    t_in_item     item;
    t_ctrl_cmd    cmd;
    t_ctrl_status status;
    logic         in_ready;

    // Gather the input fields into one item.
    always_comb begin
        item.kind         = i_in.kind;
        item.real_sample  = i_in.real_sample;
        item.imag_sample  = i_in.imag_sample;
        item.read_channel = i_in.read_channel;
        item.read_antenna = i_in.read_antenna;
        item.read_bin     = i_in.read_bin;
    end

    assign i_in.ready = in_ready;

    chs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_kind  (i_in.kind),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    chs_datapath #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_ANTENNAS (MAX_ANTENNAS),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_item       (item),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_real_count (o_out.real_count),
        .o_imag_count (o_out.imag_count)
    );

endmodule

`default_nettype wire

// ===== tb/sv/complex_sample_histogram_test.sv =====
`timescale 1ns / 1ps

module complex_sample_histogram_test;
    import chs_pkg::*;

    // Sizes of the block as built here.
    localparam int MAX_CH        = 64;
    localparam int MAX_ANT       = 16;
    localparam int PARTS         = 2;
    localparam int CLEAR_SWEEP   = MAX_CH * MAX_ANT * BIN_COUNT;
    localparam int QUIET_LIMIT   = 3 * CLEAR_SWEEP;
    localparam int IDLE_SETTLE   = 8;
    localparam int END_SETTLE    = 20;
    localparam int PHASE_ITEMS   = 118;
    localparam int PHASE_COUNT   = 8;

    localparam logic [1:0]       KIND_UNUSED   = 2'd3;
    localparam logic [BIN_W-1:0] SAMPLE_OFFSET = 8'h80;
    localparam logic [OUT_W-1:0] COUNT_MAX     = '1;

    // Both counts of one bin, as returned by a read item.
    typedef struct packed {
        logic [OUT_W-1:0] real_count;
        logic [OUT_W-1:0] imag_count;
    } t_bin_pair;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    chs_in_if  in_ch ();
    chs_out_if out_ch ();

    complex_sample_histogram i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Items waiting to be sent and bin counts waiting to come back.
    t_in_item  pending_items[$];
    t_bin_pair bin_pair_q[$];

    // Shadow of the histogram store, the frame position and the registers.
    logic [OUT_W-1:0]     hist_counts[int];
    logic [RD_CH_W-1:0]   frame_channel;
    logic [RD_ANT_W-1:0]  frame_antenna;
    logic [CFG_CH_W-1:0]  cfg_channels;
    logic [CFG_ANT_W-1:0] cfg_antennas;

    int error_count;
    int sample_count;
    int read_count;
    int pairs_checked;
    int setting_count;
    int in_gap;
    int out_stall;
    int quiet_cycles;
    bit calm;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns mismatch: %s", $time, what);
        error_count++;
    endtask

    // A register of zero means one; above the maximum it means the maximum.
    function automatic int limit_count(input int value, input int maxv);
        if (value == 0)
            return 1;
        if (value > maxv)
            return maxv;
        return value;
    endfunction

    function automatic int store_index(input int ch, input int ant, input int part,
                                       input int bin);
        return ((ch * MAX_ANT + ant) * PARTS + part) * BIN_COUNT + bin;
    endfunction

    function automatic logic [OUT_W-1:0] bin_value(input int idx);
        if (hist_counts.exists(idx))
            return hist_counts[idx];
        return '0;
    endfunction

    // Saturating increment of one counter.
    task automatic bump_bin(input int idx);
        logic [OUT_W-1:0] count;
        count = bin_value(idx);
        if (count != COUNT_MAX)
            hist_counts[idx] = count + 1'b1;
    endtask

    // Apply one accepted item to the shadow state; reads queue their result.
    task automatic histogram_update(input t_in_item item);
        logic [BIN_W-1:0] re_bin;
        logic [BIN_W-1:0] im_bin;
        int n_ch;
        int n_ant;
        int ch;
        int ant;
        t_bin_pair pair;
        case (item.kind)
            KIND_SAMPLE: begin
                re_bin = item.real_sample ^ SAMPLE_OFFSET;
                im_bin = item.imag_sample ^ SAMPLE_OFFSET;
                n_ch = limit_count(int'(cfg_channels), MAX_CH);
                n_ant = limit_count(int'(cfg_antennas), MAX_ANT);
                ch = int'(frame_channel);
                ant = int'(frame_antenna);
                if (ch < MAX_CH && ant < MAX_ANT) begin
                    bump_bin(store_index(ch, ant, 0, int'(re_bin)));
                    bump_bin(store_index(ch, ant, 1, int'(im_bin)));
                end
                // A position beyond a reduced count wraps on its next advance.
                if (ant + 1 >= n_ant) begin
                    frame_antenna = '0;
                    frame_channel = (ch + 1 >= n_ch) ? '0 : RD_CH_W'(ch + 1);
                end else begin
                    frame_antenna = RD_ANT_W'(ant + 1);
                end
                sample_count++;
            end
            KIND_READ: begin
                ch = int'(item.read_channel);
                ant = int'(item.read_antenna);
                pair = '0;
                if (ch < MAX_CH && ant < MAX_ANT) begin
                    pair.real_count = bin_value(store_index(ch, ant, 0, int'(item.read_bin)));
                    pair.imag_count = bin_value(store_index(ch, ant, 1, int'(item.read_bin)));
                end
                bin_pair_q.push_back(pair);
                read_count++;
            end
            KIND_CLEAR: begin
                hist_counts.delete();
                frame_channel = '0;
                frame_antenna = '0;
            end
            default: begin
                // The unused kind changes nothing.
            end
        endcase
    endtask

    // Every field random; callers then set the ones that matter.
    function automatic t_in_item random_fields();
        t_in_item item;
        item.kind = KIND_W'($urandom);
        item.real_sample = SAMPLE_W'($urandom);
        item.imag_sample = SAMPLE_W'($urandom);
        item.read_channel = RD_CH_W'($urandom);
        item.read_antenna = RD_ANT_W'($urandom);
        item.read_bin = BIN_W'($urandom);
        return item;
    endfunction

    task automatic push_sample(input logic signed [SAMPLE_W-1:0] re,
                               input logic signed [SAMPLE_W-1:0] im);
        t_in_item item;
        item = random_fields();
        item.kind = KIND_SAMPLE;
        item.real_sample = re;
        item.imag_sample = im;
        pending_items.push_back(item);
    endtask

    task automatic push_read(input int ch, input int ant, input int bin);
        t_in_item item;
        item = random_fields();
        item.kind = KIND_READ;
        item.read_channel = RD_CH_W'(ch);
        item.read_antenna = RD_ANT_W'(ant);
        item.read_bin = BIN_W'(bin);
        pending_items.push_back(item);
    endtask

    task automatic push_kind(input logic [KIND_W-1:0] kind);
        t_in_item item;
        item = random_fields();
        item.kind = kind;
        pending_items.push_back(item);
    endtask

    // Mostly samples near zero and reads aimed at the frame in use, so that
    // reads find counts; the rest is full-range values and unused kinds.
    task automatic push_random_item();
        int roll;
        int n_ch;
        int n_ant;
        int ch;
        int ant;
        int bin;
        roll = $urandom_range(0, 99);
        n_ch = limit_count(int'(cfg_channels), MAX_CH);
        n_ant = limit_count(int'(cfg_antennas), MAX_ANT);
        if (roll < 60) begin
            if ($urandom_range(0, 9) < 7)
                push_sample(SAMPLE_W'(int'($urandom_range(0, 7)) - 4),
                            SAMPLE_W'(int'($urandom_range(0, 7)) - 4));
            else
                push_sample(SAMPLE_W'($urandom), SAMPLE_W'($urandom));
        end else if (roll < 94) begin
            ch = ($urandom_range(0, 4) != 0) ? $urandom_range(0, n_ch - 1)
                                              : $urandom_range(0, MAX_CH - 1);
            ant = ($urandom_range(0, 4) != 0) ? $urandom_range(0, n_ant - 1)
                                               : $urandom_range(0, MAX_ANT - 1);
            bin = ($urandom_range(0, 3) != 0) ? $urandom_range(124, 131)
                                               : $urandom_range(0, BIN_COUNT - 1);
            push_read(ch, ant, bin);
        end else begin
            push_kind(KIND_UNUSED);
        end
    endtask

    // Write both registers on consecutive edges, holding the enable high.
    task automatic set_frame_shape(input logic [CFG_DATA_W-1:0] channels,
                                   input logic [CFG_DATA_W-1:0] antennas);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_CHANNELS;
        cfg_data <= channels;
        cfg_channels = channels[CFG_CH_W-1:0];
        @(posedge i_clk);
        cfg_index <= CFG_ANTENNAS;
        cfg_data <= antennas;
        cfg_antennas = antennas[CFG_ANT_W-1:0];
        @(posedge i_clk);
        cfg_we <= 1'b0;
        setting_count++;
    endtask

    task automatic wait_for_idle();
        while (pending_items.size() != 0 || bin_pair_q.size() != 0)
            @(posedge i_clk);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    // Driver: presents the oldest pending item, removing it once accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                histogram_update(pending_items.pop_front());
            if (!in_ch.valid || in_ch.ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_ch.valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    in_ch.valid <= 1'b1;
                    in_ch.kind <= pending_items[0].kind;
                    in_ch.real_sample <= pending_items[0].real_sample;
                    in_ch.imag_sample <= pending_items[0].imag_sample;
                    in_ch.read_channel <= pending_items[0].read_channel;
                    in_ch.read_antenna <= pending_items[0].read_antenna;
                    in_ch.read_bin <= pending_items[0].read_bin;
                    if (!calm && $urandom_range(0, 7) == 0)
                        in_gap = $urandom_range(1, 18);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each returned pair and stalls the output in bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (bin_pair_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d / %0d",
                                              out_ch.real_count, out_ch.imag_count));
                end else begin
                    if (out_ch.real_count != bin_pair_q[0].real_count)
                        report_mismatch($sformatf("real count %0d, expected %0d",
                                                  out_ch.real_count,
                                                  bin_pair_q[0].real_count));
                    if (out_ch.imag_count != bin_pair_q[0].imag_count)
                        report_mismatch($sformatf("imag count %0d, expected %0d",
                                                  out_ch.imag_count,
                                                  bin_pair_q[0].imag_count));
                    void'(bin_pair_q.pop_front());
                    pairs_checked++;
                end
            end
            if (out_stall > 0) begin
                out_stall--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0)
                    out_stall = $urandom_range(1, 18);
            end
        end
    end

    // Watchdog on cycles without any handshake; allows for a full clear sweep.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Stimulus: directed items at the reset shape, then random phases.
    initial begin
        logic [CFG_DATA_W-1:0] shape_channels[PHASE_COUNT];
        logic [CFG_DATA_W-1:0] shape_antennas[PHASE_COUNT];

        shape_channels = '{7'd1, 7'd3, 7'd64, 7'd0, 7'h7F, 7'd5, 7'd2, 7'd4};
        shape_antennas = '{7'd1, 7'd2, 7'd16, 7'd0, 7'h7F, 7'd3, 7'h55, 7'd5};

        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_CHANNELS;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_SAMPLE;
        in_ch.real_sample = '0;
        in_ch.imag_sample = '0;
        in_ch.read_channel = '0;
        in_ch.read_antenna = '0;
        in_ch.read_bin = '0;
        out_ch.ready = 1'b0;
        hist_counts.delete();
        frame_channel = '0;
        frame_antenna = '0;
        cfg_channels = CFG_CH_RESET;
        cfg_antennas = CFG_ANT_RESET;
        error_count = 0;
        sample_count = 0;
        read_count = 0;
        pairs_checked = 0;
        setting_count = 0;
        in_gap = 0;
        out_stall = 0;
        quiet_cycles = 0;
        calm = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // End bins for antennas 0 and 1, middle bins for antennas 2 and 3.
        push_sample(-8'sd128, 8'sd127);
        push_sample(8'sd127, -8'sd128);
        push_kind(KIND_UNUSED);
        push_sample(8'sd0, -8'sd1);
        push_sample(-8'sd1, 8'sd0);
        push_read(0, 0, 0);
        push_read(0, 0, 255);
        push_read(0, 1, 255);
        push_read(0, 1, 0);
        push_read(0, 2, 128);
        push_read(0, 3, 127);
        push_read(0, 4, 128);
        // Highest channel and antenna, past the configured channel count.
        push_read(MAX_CH - 1, MAX_ANT - 1, 255);
        // After a clear the store is empty and the frame restarts.
        push_kind(KIND_CLEAR);
        push_read(0, 0, 0);
        push_read(0, 2, 128);
        push_sample(8'sd5, -8'sd5);
        push_sample(8'sd5, 8'sd5);
        push_read(0, 0, 133);
        push_read(0, 0, 123);
        push_read(0, 1, 133);
        wait_for_idle();

        // Each phase changes the frame shape mid frame and sends random items.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            set_frame_shape(shape_channels[phase], shape_antennas[phase]);
            if (phase == PHASE_COUNT - 1)
                calm = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_random_item();
            wait_for_idle();
        end

        repeat (END_SETTLE) @(posedge i_clk);
        $display("Sent %0d samples and %0d reads over %0d frame shapes;",
                 sample_count, read_count, setting_count + 1);
        $display("%0d bin count pairs were compared, %0d mismatches.",
                 pairs_checked, error_count);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
src/chs_pkg.sv
src/chs_in_if.sv
src/chs_out_if.sv
src/chs_ctrl.sv
src/chs_datapath.sv
src/complex_sample_histogram.sv
tb/sv/complex_sample_histogram_test.sv
